[src/sbpf_pkg.sv]
package sbpf_pkg;

    localparam int NUM_BARS   = 75;
    localparam int FRAC_BITS  = 8;
    localparam int IDX_W      = 7;
    localparam int LEVEL_W    = 16;
    localparam int SPEED_W    = 24;
    localparam int SPEED_FRAC = 16;
    localparam int ADDR_W     = $clog2(NUM_BARS);
    localparam int CD_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int DROP_SHIFT  = SPEED_FRAC - FRAC_BITS;
    localparam int MUL_SHIFT   = 28;
    localparam int MUL_W       = 29;
    localparam int PROD_W      = SPEED_W + MUL_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    localparam logic [SPEED_W-1:0] SPEED_INIT = SPEED_W'(((64'd1 << SPEED_FRAC) + 64'd50) / 64'd100);

    // bar step k/100 rounded to nearest in level format
    localparam logic [LEVEL_W-1:0] BAR_STEP [5] = '{
        LEVEL_W'((64'd34  * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100),
        LEVEL_W'((64'd50  * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100),
        LEVEL_W'((64'd100 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100),
        LEVEL_W'((64'd130 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100),
        LEVEL_W'((64'd160 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100)
    };

    // f/10 scaled by 2^28, rounded up: exact floor(speed*f/10) for 24-bit speed
    localparam logic [MUL_W-1:0] PEAK_MUL [5] = '{
        MUL_W'(((64'd12 << MUL_SHIFT) + 64'd9) / 64'd10),
        MUL_W'(((64'd13 << MUL_SHIFT) + 64'd9) / 64'd10),
        MUL_W'(((64'd14 << MUL_SHIFT) + 64'd9) / 64'd10),
        MUL_W'(((64'd15 << MUL_SHIFT) + 64'd9) / 64'd10),
        MUL_W'(((64'd16 << MUL_SHIFT) + 64'd9) / 64'd10)
    };

    localparam logic [CD_W-1:0] REDRAW_INTERVAL [4] = '{4'd1, 4'd2, 4'd4, 4'd8};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_MODE   = 2'd0,
        REG_BAR_FALLOFF    = 2'd1,
        REG_PEAK_FALLOFF   = 2'd2,
        REG_REFRESH        = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic       display_mode;
        logic [2:0] bar_falloff_select;
        logic [2:0] peak_falloff_select;
        logic [1:0] refresh_select;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] bar;
        logic [LEVEL_W-1:0] peak;
        logic [SPEED_W-1:0] speed;
    } bar_state_t;

    localparam int STATE_W = $bits(bar_state_t);

    function automatic logic [2:0] sel5(input logic [2:0] s);
        return (s > 3'd4) ? 3'd4 : s;
    endfunction

    function automatic logic [LEVEL_W-1:0] level_scale(input logic [7:0] lv);
        logic [31:0] w;
        w = 32'(lv) << FRAC_BITS;
        return (w > 32'(LEVEL_MAX)) ? LEVEL_MAX : w[LEVEL_W-1:0];
    endfunction

endpackage

[src/sbpf_ram.sv]
module sbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/sbpf_update.sv]
module sbpf_update (
    input  sbpf_pkg::cfg_t       cfg,
    input  sbpf_pkg::bar_state_t cur,
    input  logic                 has_level,
    input  logic [7:0]           level,
    input  logic                 tick,
    output sbpf_pkg::bar_state_t nxt
);

    import sbpf_pkg::*;

    logic [LEVEL_W-1:0] newlv;
    logic [2:0]         bsel;
    logic [2:0]         psel;
    logic [LEVEL_W-1:0] step;
    logic               capture;
    logic               fall;
    logic               raise;
    logic               decay;
    logic [LEVEL_W-1:0] bar_new;
    logic [SPEED_W-1:0] drop;
    logic [SPEED_W-1:0] peak_ext;
    logic [LEVEL_W-1:0] peak_sub;
    logic [LEVEL_W-1:0] peak_dec;
    logic [PROD_W-1:0]  prod;
    logic [SPEED_W:0]   scaled;
    logic [SPEED_W-1:0] speed_mul;

    always_comb
    begin
        newlv   = level_scale(level);
        bsel    = sel5(cfg.bar_falloff_select);
        psel    = sel5(cfg.peak_falloff_select);
        step    = BAR_STEP[bsel];

        capture = !cfg.display_mode && has_level && (newlv > cur.bar);
        fall    = !cfg.display_mode && !capture && tick;
        raise   = capture && (newlv > cur.peak);
        decay   = ((capture && !raise) || fall) && (cur.peak != '0);

        if (capture)
        begin
            bar_new = newlv;
        end
        else if (fall)
        begin
            bar_new = (cur.bar > step) ? cur.bar - step : '0;
        end
        else if (cfg.display_mode && has_level)
        begin
            bar_new = newlv;
        end
        else
        begin
            bar_new = cur.bar;
        end

        drop     = cur.speed >> DROP_SHIFT;
        peak_ext = SPEED_W'(cur.peak);
        peak_sub = (peak_ext > drop) ? LEVEL_W'(peak_ext - drop) : '0;
        peak_dec = (peak_sub < bar_new) ? bar_new : peak_sub;

        prod      = PROD_W'(cur.speed) * PROD_W'(PEAK_MUL[psel]);
        scaled    = prod[MUL_SHIFT +: SPEED_W+1];
        speed_mul = scaled[SPEED_W] ? SPEED_MAX : scaled[SPEED_W-1:0];

        nxt.bar = bar_new;
        if (raise)
        begin
            nxt.peak  = newlv;
            nxt.speed = SPEED_INIT;
        end
        else if (decay)
        begin
            nxt.peak  = peak_dec;
            nxt.speed = speed_mul;
        end
        else
        begin
            nxt.peak  = cur.peak;
            nxt.speed = cur.speed;
        end
    end

endmodule

[src/spectrum_bar_peak_falloff.sv]
// path: word and its state read enter the input register, then the result register
// throughput: one word per cycle while the output is not stalled, bounded by the single
//   per-bar state read-modify-write; a bypass register covers back-to-back words on one bar
// reset: valid bits, pipeline valids, refresh countdown and config register clear at once;
//   a bar never written reads as zero, so there is no clearing pass
module spectrum_bar_peak_falloff (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [sbpf_pkg::IDX_W-1:0]      bar_index,
    input  logic                            has_level,
    input  logic [7:0]                      level,
    input  logic                            tick,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [sbpf_pkg::LEVEL_W-1:0]    bar_out,
    output logic [sbpf_pkg::LEVEL_W-1:0]    peak_out,
    output logic [sbpf_pkg::IDX_W-1:0]      bar_echo,
    output logic                            redraw,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbpf_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sbpf_pkg::*;

    cfg_t cfg_reg;

    logic               accept;
    logic               out_free;

    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_has_level_reg;
    logic [7:0]         s1_level_reg;
    logic               s1_tick_reg;
    logic               s1_in_range;
    logic [ADDR_W-1:0]  s1_addr;

    logic [NUM_BARS-1:0] vld_reg;
    logic                byp_valid_reg;
    logic [ADDR_W-1:0]   byp_addr_reg;
    bar_state_t          byp_data_reg;
    logic                byp_hit;

    logic [STATE_W-1:0] ram_rd_data;
    bar_state_t         cur;
    bar_state_t         nxt;
    logic               wr_en;

    logic [CD_W-1:0]    cd_reg;
    logic [CD_W-1:0]    cd_next;
    logic               last_tick;
    logic               redraw_hit;

    logic               result_valid_reg;
    logic [LEVEL_W-1:0] bar_out_reg;
    logic [LEVEL_W-1:0] peak_out_reg;
    logic [IDX_W-1:0]   bar_echo_reg;
    logic               redraw_reg;

    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DISPLAY_MODE: cfg_reg.display_mode        <= cfg_data[0];
                REG_BAR_FALLOFF:  cfg_reg.bar_falloff_select  <= cfg_data[2:0];
                REG_PEAK_FALLOFF: cfg_reg.peak_falloff_select <= cfg_data[2:0];
                REG_REFRESH:      cfg_reg.refresh_select      <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg       <= bar_index;
            s1_has_level_reg <= has_level;
            s1_level_reg     <= level;
            s1_tick_reg      <= tick;
        end
    end

    assign s1_in_range = 32'(s1_idx_reg) < NUM_BARS;
    assign s1_addr     = ADDR_W'(s1_idx_reg);
    assign wr_en       = s1_valid_reg && out_free && s1_in_range;

    sbpf_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_BARS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (nxt),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(bar_index)),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            byp_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            vld_reg[s1_addr] <= 1'b1;
            byp_valid_reg    <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_addr_reg <= s1_addr;
            byp_data_reg <= nxt;
        end
    end

    // latest write wins over the memory read taken in the same edge
    assign byp_hit = byp_valid_reg && (byp_addr_reg == s1_addr);

    always_comb
    begin
        if (!s1_in_range)
        begin
            cur = '0;
        end
        else if (byp_hit)
        begin
            cur = byp_data_reg;
        end
        else if (vld_reg[s1_addr])
        begin
            cur = ram_rd_data;
        end
        else
        begin
            cur = '0;
        end
    end

    sbpf_update u_update (
        .cfg       (cfg_reg),
        .cur       (cur),
        .has_level (s1_has_level_reg),
        .level     (s1_level_reg),
        .tick      (s1_tick_reg),
        .nxt       (nxt)
    );

    assign last_tick  = s1_tick_reg && (s1_idx_reg == IDX_W'(NUM_BARS - 1));
    assign redraw_hit = last_tick && (cd_reg == '0);

    always_comb
    begin
        if (redraw_hit)
        begin
            cd_next = REDRAW_INTERVAL[cfg_reg.refresh_select] - CD_W'(1);
        end
        else if (last_tick)
        begin
            cd_next = cd_reg - CD_W'(1);
        end
        else
        begin
            cd_next = cd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg <= '0;
        end
        else if (s1_valid_reg && out_free)
        begin
            cd_reg <= cd_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            bar_out_reg  <= s1_in_range ? nxt.bar : '0;
            peak_out_reg <= s1_in_range ? nxt.peak : '0;
            bar_echo_reg <= s1_idx_reg;
            redraw_reg   <= redraw_hit;
        end
    end

    assign result_valid = result_valid_reg;
    assign bar_out      = bar_out_reg;
    assign peak_out     = peak_out_reg;
    assign bar_echo     = bar_echo_reg;
    assign redraw       = redraw_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid_reg))
        else $error("input stalled with a free stage");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(s1_addr) < NUM_BARS))
        else $error("state write outside the bar range");

    a_redraw_last_bar: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && redraw) |-> (bar_echo == IDX_W'(NUM_BARS - 1)))
        else $error("redraw on a bar other than the last");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (32'(bar_echo) >= NUM_BARS))
            |-> (bar_out == '0 && peak_out == '0 && !redraw))
        else $error("out-of-range bar gave nonzero result");

endmodule

[bench/spectrum_bar_peak_falloff_tb.sv]
module spectrum_bar_peak_falloff_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbpf_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] bar;
        logic [LEVEL_W-1:0] peak;
        logic [IDX_W-1:0]   bar_id;
        logic               redraw;
    } meter_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic               hl;
        logic [7:0]         lv;
        logic               tk;
        logic               typed;
        logic [LEVEL_W-1:0] want_bar;
        logic [LEVEL_W-1:0] want_peak;
        logic               want_redraw;
    } stim_row_t;

    typedef struct packed {
        logic       mode;
        logic [2:0] bsel;
        logic [2:0] psel;
        logic [1:0] rsel;
    } meter_cfg_t;

    localparam int unsigned STEP_PCT [5]      = '{34, 50, 100, 130, 160};
    localparam int unsigned GROWTH_TENTHS [5] = '{12, 13, 14, 15, 16};
    localparam int unsigned FRAME_TICKS [4]   = '{1, 2, 4, 8};
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 200;
    localparam int QUIET_PHASE    = 3;
    localparam int DIRECTED_ROWS  = 19;

    localparam meter_cfg_t PHASE_CFG [6] = '{
        '{1'b0, 3'd4, 3'd4, 2'd3},
        '{1'b0, 3'd7, 3'd7, 2'd1},
        '{1'b1, 3'd0, 3'd0, 2'd2},
        '{1'b0, 3'd0, 3'd0, 2'd0},
        '{1'b0, 3'd5, 3'd6, 2'd3},
        '{1'b1, 3'd7, 3'd2, 2'd0}
    };

    // first rows run with every register at its reset value
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{7'd0,   1'b0, 8'd0,   1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0},
        '{7'd0,   1'b1, 8'd255, 1'b0, 1'b1, 16'hFF00, 16'hFF00, 1'b0},
        '{7'd0,   1'b0, 8'd0,   1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{7'd0,   1'b1, 8'd10,  1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{7'd1,   1'b1, 8'd200, 1'b0, 1'b1, 16'hC800, 16'hC800, 1'b0},
        '{7'd1,   1'b1, 8'd100, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{7'd1,   1'b0, 8'd0,   1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{7'd1,   1'b0, 8'd0,   1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{7'd1,   1'b0, 8'd0,   1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{7'd1,   1'b1, 8'd199, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{7'd74,  1'b0, 8'd0,   1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1},
        '{7'd74,  1'b0, 8'd0,   1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1},
        '{7'd74,  1'b1, 8'd1,   1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{7'd75,  1'b1, 8'd255, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0},
        '{7'd127, 1'b1, 8'd255, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0},
        '{7'd64,  1'b1, 8'd85,  1'b0, 1'b1, 16'h5500, 16'h5500, 1'b0},
        '{7'd42,  1'b1, 8'd170, 1'b1, 1'b1, 16'hAA00, 16'hAA00, 1'b0},
        '{7'd0,   1'b0, 8'd0,   1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{7'd127, 1'b0, 8'd0,   1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    logic [IDX_W-1:0]      bar_index;
    logic                  has_level;
    logic [7:0]            level;
    logic                  tick;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [LEVEL_W-1:0]    bar_out;
    logic [LEVEL_W-1:0]    peak_out;
    logic [IDX_W-1:0]      bar_echo;
    logic                  redraw;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [LEVEL_W-1:0] bar_mem [NUM_BARS];
    logic [LEVEL_W-1:0] peak_mem [NUM_BARS];
    logic [SPEED_W-1:0] speed_mem [NUM_BARS];
    logic [CD_W-1:0]    countdown;
    logic               mode_q;
    logic [2:0]         bar_sel_q;
    logic [2:0]         peak_sel_q;
    logic [1:0]         refresh_sel_q;

    meter_word_t due_words [$];
    meter_word_t seen_word;
    meter_word_t due_word;
    int          mismatches = 0;
    bit          no_gaps = 1'b0;

    spectrum_bar_peak_falloff uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .bar_index    (bar_index),
        .has_level    (has_level),
        .level        (level),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .bar_out      (bar_out),
        .peak_out     (peak_out),
        .bar_echo     (bar_echo),
        .redraw       (redraw),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void decay_peak(input int b);
        logic [LEVEL_W-1:0] drop;
        logic [63:0]        grown;
        int unsigned        sel;
        sel = (peak_sel_q > 3'd4) ? 4 : peak_sel_q;
        drop = LEVEL_W'(speed_mem[b] >> (SPEED_FRAC - FRAC_BITS));
        peak_mem[b] = (peak_mem[b] > drop) ? peak_mem[b] - drop : '0;
        grown = 64'(speed_mem[b]) * 64'(GROWTH_TENTHS[sel]) / 64'd10;
        speed_mem[b] = (grown > 64'hFF_FFFF) ? 24'hFF_FFFF : grown[SPEED_W-1:0];
        if (peak_mem[b] < bar_mem[b])
            peak_mem[b] = bar_mem[b];
    endfunction

    function automatic meter_word_t meter_update(input logic [IDX_W-1:0] idx, input logic hl,
                                                 input logic [7:0] lv, input logic tk);
        meter_word_t        w;
        logic [31:0]        wide;
        logic [LEVEL_W-1:0] scaled;
        logic [LEVEL_W-1:0] step;
        int unsigned        sel;
        int                 b;
        w = '0;
        w.bar_id = idx;
        if (idx >= NUM_BARS)
            return w;
        b = idx;
        wide = 32'(lv) << FRAC_BITS;
        scaled = (wide > 32'hFFFF) ? 16'hFFFF : wide[LEVEL_W-1:0];
        if (!mode_q)
        begin
            if (hl && scaled > bar_mem[b])
            begin
                bar_mem[b] = scaled;
                if (scaled > peak_mem[b])
                begin
                    peak_mem[b] = scaled;
                    speed_mem[b] = SPEED_W'(((64'd1 << SPEED_FRAC) + 64'd50) / 64'd100);
                end
                else if (peak_mem[b] != '0)
                    decay_peak(b);
            end
            else if (tk)
            begin
                sel = (bar_sel_q > 3'd4) ? 4 : bar_sel_q;
                step = LEVEL_W'((STEP_PCT[sel] * (32'd1 << FRAC_BITS) + 32'd50) / 32'd100);
                bar_mem[b] = (bar_mem[b] > step) ? bar_mem[b] - step : '0;
                if (peak_mem[b] != '0)
                    decay_peak(b);
            end
        end
        else if (hl)
            bar_mem[b] = scaled;
        if (tk && idx == NUM_BARS - 1)
        begin
            if (countdown == '0)
            begin
                w.redraw = 1'b1;
                countdown = CD_W'(FRAME_TICKS[refresh_sel_q]);
            end
            countdown = countdown - 1'b1;
        end
        w.bar = bar_mem[b];
        w.peak = peak_mem[b];
        return w;
    endfunction

    task automatic send_item(input logic [IDX_W-1:0] idx, input logic hl, input logic [7:0] lv,
                             input logic tk, input logic typed, input meter_word_t want);
        meter_word_t w;
        while (!no_gaps && $urandom_range(99) < 12)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        bar_index <= idx;
        has_level <= hl;
        level <= lv;
        tick <= tk;
        do
            @(posedge clk);
        while (item_stall);
        w = meter_update(idx, hl, lv, tk);
        due_words.push_back(typed ? want : w);
    endtask

    task automatic random_item();
        int unsigned      pick;
        logic [IDX_W-1:0] idx;
        logic             hl;
        logic [7:0]       lv;
        logic             tk;
        pick = $urandom_range(99);
        lv = 8'($urandom);
        hl = 1'($urandom_range(1));
        tk = 1'($urandom_range(1));
        if (pick < 8)
            idx = IDX_W'($urandom_range(127, NUM_BARS));
        else if (pick < 40)
        begin
            // long falloff runs on two bars so peak speeds climb to saturation
            idx = $urandom_range(1) ? IDX_W'(NUM_BARS - 1) : '0;
            tk = 1'b1;
            hl = ($urandom_range(9) == 0);
        end
        else if (pick < 50)
            idx = IDX_W'(NUM_BARS - 1);
        else
            idx = IDX_W'($urandom_range(NUM_BARS - 1));
        send_item(idx, hl, lv, tk, 1'b0, '0);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (r)
            REG_DISPLAY_MODE: mode_q = data[0];
            REG_BAR_FALLOFF:  bar_sel_q = data[2:0];
            REG_PEAK_FALLOFF: peak_sel_q = data[2:0];
            REG_REFRESH:      refresh_sel_q = data[1:0];
            default:          ;
        endcase
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side: random stall and in-order compare
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen_word = '{bar_out, peak_out, bar_echo, redraw};
            if (due_words.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result word: bar %0d", bar_echo);
                mismatches++;
            end
            else
            begin
                due_word = due_words.pop_front();
                if (seen_word.bar !== due_word.bar || seen_word.peak !== due_word.peak ||
                    seen_word.bar_id !== due_word.bar_id || seen_word.redraw !== due_word.redraw)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected bar %h peak %h echo %0d redraw %b, got bar %h peak %h echo %0d redraw %b",
                                 due_word.bar, due_word.peak, due_word.bar_id, due_word.redraw,
                                 seen_word.bar, seen_word.peak, seen_word.bar_id, seen_word.redraw);
                    mismatches++;
                end
            end
        end
        result_stall <= !no_gaps && ($urandom_range(99) < 12);
    end

    initial
    begin
        meter_cfg_t s;
        meter_word_t want;
        rst_n = 1'b0;
        item_valid = 1'b0;
        bar_index = '0;
        has_level = 1'b0;
        level = '0;
        tick = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_DISPLAY_MODE;
        cfg_data = '0;
        for (int i = 0; i < NUM_BARS; i++)
        begin
            bar_mem[i] = '0;
            peak_mem[i] = '0;
            speed_mem[i] = '0;
        end
        countdown = '0;
        mode_q = 1'b0;
        bar_sel_q = '0;
        peak_sel_q = '0;
        refresh_sel_q = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            want = '{DIRECTED[r].want_bar, DIRECTED[r].want_peak, DIRECTED[r].idx,
                     DIRECTED[r].want_redraw};
            send_item(DIRECTED[r].idx, DIRECTED[r].hl, DIRECTED[r].lv, DIRECTED[r].tk,
                      DIRECTED[r].typed, want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            if (ph < 6)
                s = PHASE_CFG[ph];
            else
                s = '{($urandom_range(3) == 0), 3'($urandom), 3'($urandom), 2'($urandom)};
            write_reg(REG_DISPLAY_MODE, {7'($urandom), s.mode});
            write_reg(REG_BAR_FALLOFF, {5'($urandom), s.bsel});
            write_reg(REG_PEAK_FALLOFF, {5'($urandom), s.psel});
            write_reg(REG_REFRESH, {6'($urandom), s.rsel});
            cfg_valid <= 1'b0;
            no_gaps = (ph == QUIET_PHASE);
            repeat (PHASE_ITEMS) random_item();
            no_gaps = 1'b0;
        end

        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[spectrum_bar_peak_falloff.f]
src/sbpf_pkg.sv
src/sbpf_ram.sv
src/sbpf_update.sv
src/spectrum_bar_peak_falloff.sv
bench/spectrum_bar_peak_falloff_tb.sv
